### hw/rtl/bpra_pkg.sv
// Shared widths and controller/datapath command and status types of the page run allocator.
`default_nettype none
package bpra_pkg;

	localparam int START_W   = 16;
	localparam int COUNT_W   = 17;
	localparam int PAGE_W    = 16;
	localparam int SUM_W     = 18;
	localparam int WORD_BITS = 8;
	localparam int BIT_SEL_W = 3;

	typedef struct packed {
		logic latch;
		logic dispatch;
		logic fail;
		logic scan_rd;
		logic scan_step;
		logic rmw_rd;
		logic rmw_wr;
		logic clr_step;
		logic rsp_load;
	} bpra_cmd_t;

	typedef struct packed {
		logic op_alloc;
		logic rel_empty;
		logic at_limit;
		logic run_hit;
		logic word_end;
		logic rmw_last;
		logic clr_last;
		logic rsp_full;
	} bpra_status_t;

endpackage
`default_nettype wire

### hw/rtl/bpra_req_if.sv
// Request channel: one release or allocate word.
`default_nettype none
interface bpra_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [bpra_pkg::START_W-1:0] start_page;
	logic [bpra_pkg::COUNT_W-1:0] page_count;

	modport source (output valid, operation, start_page, page_count, input ready);
	modport sink   (input valid, operation, start_page, page_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/bpra_rsp_if.sv
// Response channel: one result word per request.
`default_nettype none
interface bpra_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        success;
	logic [bpra_pkg::PAGE_W-1:0] run_page;

	modport source (output valid, success, run_page, input ready);
	modport sink   (input valid, success, run_page, output ready);
endinterface
`default_nettype wire

### hw/rtl/bitmap_page_run_allocator_unit.sv
// Top level of the bitmap page run allocator.
// Keeps one used bit per page in an 8-page-wide RAM, all pages used after reset. After reset
// a clearing pass writes every RAM word (8192 at the default), during which no request is
// taken. A release does a read-modify-write on the single RAM for each 8-page RAM word it
// touches. An allocate scans pages from the cursor, reading each RAM word it enters, then
// marks the run used with a read-modify-write of each of its words. One request is worked at
// a time; the next one is taken while the previous result waits in the output register.
`default_nettype none
module bitmap_page_run_allocator_unit #(
	parameter int PAGE_COUNT = 65536
) (
	input wire         clk,
	input wire         arst_n,
	bpra_req_if.sink   req,
	bpra_rsp_if.source rsp
);
	bpra_pkg::bpra_cmd_t    cmd;
	bpra_pkg::bpra_status_t st;
	logic                   ready;

	bpra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.st        (st),
		.cmd       (cmd)
	);

	bpra_dp #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_operation  (req.operation),
		.in_start_page (req.start_page),
		.in_page_count (req.page_count),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.rsp_success   (rsp.success),
		.rsp_run_page  (rsp.run_page)
	);

	assign req.ready = ready;
endmodule
`default_nettype wire

### hw/rtl/bpra_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bpra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bpra_ctrl.sv
// Controller state machine of the page run allocator.
`default_nettype none
module bpra_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  bpra_pkg::bpra_status_t st,
	output bpra_pkg::bpra_cmd_t    cmd
);
	typedef enum logic [7:0] {
		S_CLEAR     = 8'b0000_0001,
		S_IDLE      = 8'b0000_0010,
		S_DISPATCH  = 8'b0000_0100,
		S_SCAN_RD   = 8'b0000_1000,
		S_SCAN_TEST = 8'b0001_0000,
		S_RMW_RD    = 8'b0010_0000,
		S_RMW_WR    = 8'b0100_0000,
		S_DONE      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.dispatch = 1'b1;
				if (st.op_alloc) begin
					state_d = S_SCAN_RD;
				end else if (st.rel_empty) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RMW_RD;
				end
			end
			S_SCAN_RD: begin
				if (st.at_limit) begin
					cmd.fail = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_TEST;
				end
			end
			S_SCAN_TEST: begin
				if (st.at_limit) begin
					cmd.fail = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					if (st.run_hit) begin
						state_d = S_RMW_RD;
					end else if (st.word_end) begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_RMW_RD: begin
				cmd.rmw_rd = 1'b1;
				state_d    = S_RMW_WR;
			end
			S_RMW_WR: begin
				cmd.rmw_wr = 1'b1;
				state_d    = st.rmw_last ? S_DONE : S_RMW_RD;
			end
			S_DONE: begin
				if (!st.rsp_full) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/bpra_dp.sv
// Datapath: bitmap RAM, cursor, top bound, run counter and result register.
`default_nettype none
module bpra_dp #(
	parameter int PAGE_COUNT = 65536
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  bpra_pkg::bpra_cmd_t           cmd,
	output bpra_pkg::bpra_status_t        st,
	input  wire                           in_operation,
	input  wire  [bpra_pkg::START_W-1:0]  in_start_page,
	input  wire  [bpra_pkg::COUNT_W-1:0]  in_page_count,
	input  wire                           rsp_ready,
	output logic                          rsp_valid,
	output logic                          rsp_success,
	output logic [bpra_pkg::PAGE_W-1:0]   rsp_run_page
);
	localparam int WB    = bpra_pkg::WORD_BITS;
	localparam int LB    = bpra_pkg::BIT_SEL_W;
	localparam int CW    = $clog2(PAGE_COUNT + 1);
	localparam int DEPTH = (PAGE_COUNT + WB - 1) / WB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = (CW + 1 > bpra_pkg::SUM_W) ? CW + 1 : bpra_pkg::SUM_W;

	logic                         op_q;
	logic [bpra_pkg::START_W-1:0] start_q;
	logic [bpra_pkg::COUNT_W-1:0] cnt_q;
	logic [CW-1:0]                top_q, cursor_q, run_q, p_q, end_q;
	logic                         set_q;
	logic [AW-1:0]                clr_q;
	logic                         res_ok_q, rsp_valid_q, rsp_ok_q;
	logic [bpra_pkg::PAGE_W-1:0]  res_page_q, rsp_page_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [WB-1:0] wdata, rdata, mask, new_word;

	logic [EW-1:0] start_w, cnt_w, sum_w, end_clip_w, pc_w;
	logic [EW-1:0] cur_w, cur_next_w, run_next_w, first_w;
	logic [EW-1:0] base_w, step_w, end_w;
	logic          cur_bit;

	assign pc_w       = EW'(PAGE_COUNT);
	assign start_w    = EW'(start_q);
	assign cnt_w      = EW'(cnt_q);
	assign sum_w      = start_w + cnt_w;
	assign end_clip_w = (sum_w > pc_w) ? pc_w : sum_w;

	assign cur_w      = EW'(cursor_q);
	assign cur_next_w = cur_w + EW'(1);
	assign run_next_w = EW'(run_q) + EW'(1);
	assign first_w    = cur_next_w - cnt_w;
	assign cur_bit    = rdata[cursor_q[LB-1:0]];

	assign end_w  = EW'(end_q);
	assign base_w = EW'({p_q[CW-1:LB], LB'(0)});
	assign step_w = base_w + EW'(WB);

	always_comb begin
		for (int i = 0; i < WB; i++) begin
			mask[i] = (LB'(i) >= p_q[LB-1:0]) && ((base_w + EW'(i)) < end_w);
		end
	end

	assign new_word = set_q ? (rdata | mask) : (rdata & ~mask);

	assign we    = cmd.clr_step | cmd.rmw_wr;
	assign waddr = cmd.clr_step ? clr_q : p_q[AW+LB-1:LB];
	assign wdata = cmd.clr_step ? {WB{1'b1}} : new_word;
	assign re    = cmd.scan_rd | cmd.rmw_rd;
	assign raddr = cmd.scan_rd ? cursor_q[AW+LB-1:LB] : p_q[AW+LB-1:LB];

	bpra_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		st           = '0;
		st.op_alloc  = op_q;
		st.rel_empty = !(start_w < end_clip_w);
		st.at_limit  = cursor_q >= top_q;
		st.run_hit   = !cur_bit && (run_next_w == cnt_w);
		st.word_end  = &cursor_q[LB-1:0];
		st.rmw_last  = step_w >= end_w;
		st.clr_last  = clr_q == AW'(DEPTH - 1);
		st.rsp_full  = rsp_valid_q && !rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			cursor_q    <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.dispatch && !op_q && (end_clip_w[CW-1:0] > top_q)) begin
				top_q <= end_clip_w[CW-1:0];
			end
			if (cmd.scan_step) begin
				cursor_q <= cur_next_w[CW-1:0];
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_operation;
			start_q <= in_start_page;
			cnt_q   <= in_page_count;
		end
		if (cmd.dispatch) begin
			run_q      <= '0;
			res_ok_q   <= 1'b1;
			res_page_q <= '0;
			if (!op_q) begin
				p_q   <= start_w[CW-1:0];
				end_q <= end_clip_w[CW-1:0];
				set_q <= 1'b0;
			end
		end
		if (cmd.fail) begin
			res_ok_q   <= 1'b0;
			res_page_q <= '0;
		end
		if (cmd.scan_step) begin
			run_q <= cur_bit ? '0 : run_next_w[CW-1:0];
			if (!cur_bit && (run_next_w == cnt_w)) begin
				p_q        <= first_w[CW-1:0];
				end_q      <= cur_next_w[CW-1:0];
				set_q      <= 1'b1;
				res_page_q <= first_w[bpra_pkg::PAGE_W-1:0];
			end
		end
		if (cmd.rmw_wr && !(step_w >= end_w)) begin
			p_q <= step_w[CW-1:0];
		end
		if (cmd.rsp_load) begin
			rsp_ok_q   <= res_ok_q;
			rsp_page_q <= res_page_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp_success  = rsp_ok_q;
	assign rsp_run_page = rsp_page_q;
endmodule
`default_nettype wire

### hw/rtl/bpra_checker.sv
// Port-level checker for the page run allocator and its bind.
`default_nettype none
module bpra_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire                          rsp_success,
	input wire [bpra_pkg::PAGE_W-1:0]   rsp_run_page
);
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'((req_valid && req_ready) ? 1 : 0)
				- 2'((rsp_valid && rsp_ready) ? 1 : 0);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_page) && $stable(rsp_success))
		else $error("result word dropped or changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_success |-> rsp_run_page == '0)
		else $error("failed allocation with nonzero page");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in work");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0 && pend_q != 2'd3)
		else $error("result word without a pending request");
endmodule

bind bitmap_page_run_allocator_unit bpra_checker u_bpra_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_success  (rsp.success),
	.rsp_run_page (rsp.run_page)
);
`default_nettype wire
